@@ hw/rtl/wavhp_pkg.sv @@
// shared types and constants for the wave header parser
// no dependencies

package wavhp_pkg;

    localparam int unsigned LengthBits = 32;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_CHDR = 3'd1,
        PH_BODY = 3'd2,
        PH_PAD  = 3'd3,
        PH_DONE = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CS_WALK   = 2'd0,
        CS_DIVIDE = 2'd1,
        CS_OUTPUT = 2'd2,
        CS_FINISH = 2'd3
    } ctrl_state_t;

    localparam logic [31:0] TagRiff = 32'h46464952;
    localparam logic [31:0] TagWave = 32'h45564157;
    localparam logic [31:0] TagFmt  = 32'h20746D66;
    localparam logic [31:0] TagData = 32'h61746164;
    localparam logic [15:0] WavePcm   = 16'd1;
    localparam logic [15:0] WaveFloat = 16'd3;

    localparam logic [32:0] LengthMax = (33'd1 << LengthBits) - 33'd1;

    // ceil(2^33 / 3), exact floor(x / 3) for any 32-bit x after a shift by 33
    localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;

    // commands from controller to datapath
    typedef struct packed {
        logic step;       // consume one word
        logic finish;     // evaluate header and load the frame divider
        logic div_step;   // form the frame count
        logic clear;      // start a new file
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

@@ hw/rtl/wavhp_datapath.sv @@
// chunk walker, fmt capture, validity checks and shift/reciprocal frame divider
// depends on wavhp_pkg

module wavhp_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wavhp_pkg::dp_cmd_t     cmd,
    output wavhp_pkg::dp_status_t  stat,
    input  logic [7:0]             data_byte,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   status,
    output logic [1:0]             sample_format,
    output logic [1:0]             channel_count,
    output logic [31:0]            sample_rate,
    output logic [31:0]            frame_count,
    output logic [31:0]            data_offset
);
    import wavhp_pkg::*;

    logic [31:0] min_rate_reg, max_rate_reg;
    logic [3:0]  hcount_reg, hcount_next;   // file header index, saturates at 12
    logic [31:0] riff_len_reg, riff_len_next;
    logic [31:0] list_pos_reg, list_pos_next;
    phase_t      phase_reg, phase_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [31:0] remain_reg, remain_next;
    logic [63:0] fmt_reg, fmt_next;
    logic [15:0] bits_reg, bits_next;
    logic [4:0]  taken_reg, taken_next;
    logic        fmt_act_reg, fmt_act_next;
    logic        fmt_found_reg, fmt_found_next;
    logic        data_found_reg, data_found_next;
    logic [31:0] data_len_reg, data_len_next;
    logic [31:0] data_start_reg, data_start_next;

    // divider
    logic [31:0] num_reg, quo_reg;
    logic        by3_reg, done_reg;
    logic        ok_reg;
    logic [1:0]  code_reg, chan_reg;
    logic [31:0] rate_reg, offs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg <= 32'd8000;
            max_rate_reg <= 32'd192000;
        end
        else if (cfg_we)
        begin
            if (cfg_index) max_rate_reg <= cfg_data;
            else           min_rate_reg <= cfg_data;
        end
    end

    logic [63:0] sh_byte;
    logic [31:0] lp_inc, remain_dec, clen, space;
    logic [2:0]  hidx;

    always_comb
    begin
        hcount_next     = hcount_reg;
        riff_len_next   = riff_len_reg;
        list_pos_next   = list_pos_reg;
        phase_next      = phase_reg;
        hdr_next        = hdr_reg;
        remain_next     = remain_reg;
        fmt_next        = fmt_reg;
        bits_next       = bits_reg;
        taken_next      = taken_reg;
        fmt_act_next    = fmt_act_reg;
        fmt_found_next  = fmt_found_reg;
        data_found_next = data_found_reg;
        data_len_next   = data_len_reg;
        data_start_next = data_start_reg;
        lp_inc     = list_pos_reg + 32'd1;
        remain_dec = remain_reg - 32'd1;
        hidx       = 3'(8 - remain_reg[3:0]);
        sh_byte    = 64'(data_byte) << {hidx, 3'b000};
        clen       = hdr_next[63:32];
        space      = riff_len_reg - lp_inc;

        if (cmd.step)
        begin
            if (hcount_reg != 4'd12) hcount_next = hcount_reg + 4'd1;
            unique case (phase_reg)
                PH_HEAD:
                begin
                    if (hcount_reg < 4'd4)
                    begin
                        if (data_byte != TagRiff[{hcount_reg[1:0], 3'b000} +: 8])
                            phase_next = PH_ERR;
                    end
                    else if (hcount_reg < 4'd8)
                        riff_len_next[{hcount_reg[1:0], 3'b000} +: 8] = data_byte;
                    else if (hcount_reg < 4'd12)
                    begin
                        if (data_byte != TagWave[{hcount_reg[1:0], 3'b000} +: 8])
                            phase_next = PH_ERR;
                        else if (hcount_reg == 4'd11)
                        begin
                            if (riff_len_reg < 32'd4 || 33'(riff_len_reg) > LengthMax)
                                phase_next = PH_ERR;
                            else
                            begin
                                riff_len_next = riff_len_reg - 32'd4;
                                list_pos_next = '0;
                                if (riff_len_next == 32'd0)
                                    phase_next = PH_DONE;
                                else if (riff_len_next < 32'd8)
                                    phase_next = PH_ERR;
                                else
                                begin
                                    phase_next  = PH_CHDR;
                                    remain_next = 32'd8;
                                    hdr_next    = '0;
                                end
                            end
                        end
                    end
                end
                PH_CHDR:
                begin
                    hdr_next      = hdr_reg | sh_byte;
                    list_pos_next = lp_inc;
                    remain_next   = remain_dec;
                    clen          = hdr_next[63:32];
                    if (remain_dec == 32'd0)
                    begin
                        if (33'(clen) > LengthMax || clen > space)
                            phase_next = PH_ERR;
                        else if (hdr_next[31:0] == TagFmt && !fmt_found_reg
                                 && clen < 32'd16)
                        begin
                            fmt_found_next = 1'b1;
                            phase_next     = PH_ERR;
                        end
                        else
                        begin
                            if (hdr_next[31:0] == TagFmt && !fmt_found_reg)
                            begin
                                fmt_found_next = 1'b1;
                                fmt_act_next   = 1'b1;
                            end
                            if (hdr_next[31:0] == TagData && !data_found_reg)
                            begin
                                data_found_next = 1'b1;
                                data_len_next   = clen;
                                data_start_next = lp_inc + 32'd12;
                            end
                            if (clen == 32'd0)
                            begin
                                // zero-length chunk ends right here
                                fmt_act_next = 1'b0;
                                if (lp_inc == riff_len_reg) phase_next = PH_DONE;
                                else if (lp_inc[0]) phase_next = PH_PAD;
                                else if (space < 32'd8) phase_next = PH_ERR;
                                else
                                begin
                                    phase_next  = PH_CHDR;
                                    remain_next = 32'd8;
                                    hdr_next    = '0;
                                end
                            end
                            else
                            begin
                                phase_next  = PH_BODY;
                                remain_next = clen;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    if (fmt_act_reg && taken_reg < 5'd16)
                    begin
                        if (taken_reg < 5'd8)
                            fmt_next[{taken_reg[2:0], 3'b000} +: 8] = data_byte;
                        else if (taken_reg >= 5'd14)
                            bits_next[{taken_reg[0], 3'b000} +: 8] = data_byte;
                        taken_next = taken_reg + 5'd1;
                    end
                    list_pos_next = lp_inc;
                    remain_next   = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        fmt_act_next = 1'b0;
                        if (lp_inc == riff_len_reg) phase_next = PH_DONE;
                        else if (lp_inc[0]) phase_next = PH_PAD;
                        else if (space < 32'd8) phase_next = PH_ERR;
                        else
                        begin
                            phase_next  = PH_CHDR;
                            remain_next = 32'd8;
                            hdr_next    = '0;
                        end
                    end
                end
                PH_PAD:
                begin
                    list_pos_next = lp_inc;
                    if (lp_inc == riff_len_reg) phase_next = PH_DONE;
                    else if (space < 32'd8) phase_next = PH_ERR;
                    else
                    begin
                        phase_next  = PH_CHDR;
                        remain_next = 32'd8;
                        hdr_next    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg     <= '0;
            riff_len_reg   <= '0;
            list_pos_reg   <= '0;
            phase_reg      <= PH_HEAD;
            hdr_reg        <= '0;
            remain_reg     <= '0;
            fmt_reg        <= '0;
            bits_reg       <= '0;
            taken_reg      <= '0;
            fmt_act_reg    <= 1'b0;
            fmt_found_reg  <= 1'b0;
            data_found_reg <= 1'b0;
            data_len_reg   <= '0;
            data_start_reg <= '0;
        end
        else if (cmd.clear)
        begin
            hcount_reg     <= '0;
            riff_len_reg   <= '0;
            list_pos_reg   <= '0;
            phase_reg      <= PH_HEAD;
            hdr_reg        <= '0;
            remain_reg     <= '0;
            fmt_reg        <= '0;
            bits_reg       <= '0;
            taken_reg      <= '0;
            fmt_act_reg    <= 1'b0;
            fmt_found_reg  <= 1'b0;
            data_found_reg <= 1'b0;
            data_len_reg   <= '0;
            data_start_reg <= '0;
        end
        else
        begin
            hcount_reg     <= hcount_next;
            riff_len_reg   <= riff_len_next;
            list_pos_reg   <= list_pos_next;
            phase_reg      <= phase_next;
            hdr_reg        <= hdr_next;
            remain_reg     <= remain_next;
            fmt_reg        <= fmt_next;
            bits_reg       <= bits_next;
            taken_reg      <= taken_next;
            fmt_act_reg    <= fmt_act_next;
            fmt_found_reg  <= fmt_found_next;
            data_found_reg <= data_found_next;
            data_len_reg   <= data_len_next;
            data_start_reg <= data_start_next;
        end
    end

    // final checks on the captured header
    logic [15:0] afmt, nchan;
    logic [31:0] rate;
    logic        ok;
    logic [1:0]  code;
    logic [2:0]  width;
    logic [1:0]  shamt;
    logic        by3;

    always_comb
    begin
        afmt  = fmt_reg[15:0];
        nchan = fmt_reg[31:16];
        rate  = fmt_reg[63:32];
        code  = 2'd0;
        width = 3'd0;
        ok = phase_reg == PH_DONE && fmt_found_reg && data_found_reg
             && taken_reg == 5'd16 && rate >= min_rate_reg && rate <= max_rate_reg
             && (nchan == 16'd1 || nchan == 16'd2);
        if (afmt == WavePcm && bits_reg == 16'd8)
        begin
            width = 3'd1; code = 2'd0;
        end
        else if (afmt == WavePcm && bits_reg == 16'd16)
        begin
            width = 3'd2; code = 2'd1;
        end
        else if (afmt == WavePcm && bits_reg == 16'd24)
        begin
            width = 3'd3; code = 2'd2;
        end
        else if (afmt == WaveFloat && bits_reg == 16'd32)
        begin
            width = 3'd4; code = 2'd3;
        end
        else
            ok = 1'b0;
        // bytes per frame is 1, 2, 3, 4, 6 or 8: a shift plus an optional divide by 3
        by3 = width == 3'd3;
        unique case (width)
            3'd2:    shamt = 2'd1;
            3'd4:    shamt = 2'd2;
            default: shamt = 2'd0;
        endcase
        if (nchan == 16'd2) shamt = shamt + 2'd1;
    end

    logic [63:0] prod;
    assign prod = 64'(num_reg) * 64'(Recip3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b1;
        else if (cmd.finish)
            done_reg <= 1'b0;
        else if (cmd.div_step)
            done_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg   <= ok;
            code_reg <= code;
            chan_reg <= nchan[1:0];
            rate_reg <= rate;
            offs_reg <= data_start_reg;
            num_reg  <= data_len_reg >> shamt;
            by3_reg  <= by3;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= by3_reg ? {1'b0, prod[63:33]} : num_reg;
        end
    end

    assign stat.div_done  = done_reg;
    assign status         = !ok_reg;
    assign sample_format  = ok_reg ? code_reg : 2'd0;
    assign channel_count  = ok_reg ? chan_reg : 2'd0;
    assign sample_rate    = ok_reg ? rate_reg : 32'd0;
    assign frame_count    = ok_reg ? quo_reg : 32'd0;
    assign data_offset    = ok_reg ? offs_reg : 32'd0;

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= 5'd16) else $error("fmt capture overran");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEAD |-> list_pos_reg <= riff_len_reg)
        else $error("list position past list end");
    a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !stat.div_done) else $error("divider not loaded");

endmodule

@@ hw/rtl/wavhp_ctrl.sv @@
// controller: byte intake, final-word divide sequencing and result handshake
// depends on wavhp_pkg

module wavhp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wavhp_pkg::dp_cmd_t     cmd,
    input  wavhp_pkg::dp_status_t  stat
);
    import wavhp_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        acc;

    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_WALK:   if (acc && last_byte) state_next = CS_FINISH;
            CS_FINISH: state_next = CS_DIVIDE;
            CS_DIVIDE: if (stat.div_done) state_next = CS_OUTPUT;
            CS_OUTPUT: if (out_ready) state_next = CS_WALK;
            default:   state_next = CS_WALK;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.step     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.clear    = 1'b0;
        unique case (state_reg)
            CS_WALK:
            begin
                in_ready = 1'b1;
                // the final word is walked too, checks follow in the next cycle
                cmd.step = acc;
            end
            CS_FINISH: cmd.finish = 1'b1;
            CS_DIVIDE:
            begin
                cmd.div_step = !stat.div_done;
                cmd.clear    = 1'b1;
            end
            CS_OUTPUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= CS_WALK;
        else        state_reg <= state_next;
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.finish)) else $error("step and finish together");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("intake while result pending");
    a_fin_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == CS_DIVIDE) else $error("finish lost");

endmodule

@@ hw/rtl/wav_header_parser_unit.sv @@
// top level of the wave header parser: controller plus datapath
// depends on wavhp_pkg, wavhp_ctrl, wavhp_datapath
//
// usage
// - input channel: one file word (data_byte) per accepted handshake, from offset
//   zero, last_byte high on the final word of the file
// - every word, the final one too, is walked; the block reads one
//   word per cycle within a file
// - after the final word the header checks are registered and the frame count
//   is formed by a shift and, for 24-bit samples, a multiply by the reciprocal
//   of three in the divide state; out_valid then rises and in_ready stays low
//   until the result is taken
// - output channel: one result word per file (status and decoded fields);
//   on error status is 1 and all other fields are zero
// - a stalled receiver holds the result and the input stays blocked
// - cfg port: index 0 min_rate, index 1 max_rate; write while idle
// - reset: rates return to 8000 and 192000 Hz and the parser waits for the
//   first word of a new file

module wav_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [1:0]  sample_format,
    output logic [1:0]  channel_count,
    output logic [31:0] sample_rate,
    output logic [31:0] frame_count,
    output logic [31:0] data_offset,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import wavhp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    wavhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wavhp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (data_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .sample_format (sample_format),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .frame_count   (frame_count),
        .data_offset   (data_offset)
    );

endmodule

@@ tb/sv/wav_header_parser_unit_tb.sv @@
// testbench for the wave header parser: whole files are streamed word by word
// and each result is checked against a predictor kept inside this module
// depends on wavhp_pkg and wav_header_parser_unit

module wav_header_parser_unit_tb;
    import wavhp_pkg::*;

    typedef struct packed {
        logic        status;
        logic [1:0]  sample_format;
        logic [1:0]  channel_count;
        logic [31:0] sample_rate;
        logic [31:0] frame_count;
        logic [31:0] data_offset;
    } wav_info_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [1:0]  sample_format;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [31:0] frame_count;
    logic [31:0] data_offset;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'd0;

    localparam logic CfgMinRate = 1'b0;
    localparam logic CfgMaxRate = 1'b1;
    localparam int unsigned WatchdogLimit = 20000;

    wav_header_parser_unit dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] lim_min, lim_max;
    logic [31:0] hdr_count, list_len, list_pos, chunk_left, data_len, data_pos;
    phase_t      phase;
    logic [63:0] collect, fmt_lo;
    logic [15:0] fmt_depth;
    int unsigned fmt_got;
    logic        fmt_in_chunk, got_fmt, got_data, bad;

    wav_info_t   expected_info[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          rx_hold = 0;
    bit          rx_stalls = 1;

    function automatic void clear_parse();
        hdr_count = 0; list_len = 0; list_pos = 0; phase = PH_HEAD;
        collect = 0; chunk_left = 0; fmt_lo = 0; fmt_depth = 0; fmt_got = 0;
        fmt_in_chunk = 0; got_fmt = 0; got_data = 0; data_len = 0; data_pos = 0;
        bad = 0;
    endfunction

    function automatic void mark_bad();
        bad = 1; phase = PH_ERR;
    endfunction

    function automatic void open_header();
        if (list_len - list_pos < 8) mark_bad();
        else
        begin
            phase = PH_CHDR; chunk_left = 8; collect = 0;
        end
    endfunction

    function automatic void close_chunk();
        fmt_in_chunk = 0;
        if (list_pos == list_len) phase = PH_DONE;
        else if (list_pos[0]) phase = PH_PAD;
        else open_header();
    endfunction

    function automatic wav_info_t evaluate_file();
        wav_info_t r;
        logic [15:0] afmt, nch;
        logic [31:0] rate;
        int unsigned wid;
        bit ok;
        afmt = fmt_lo[15:0]; nch = fmt_lo[31:16]; rate = fmt_lo[63:32];
        wid = 0;
        r = '0;
        ok = phase == PH_DONE && !bad && got_fmt && got_data && fmt_got == 16;
        if (ok && (rate < lim_min || rate > lim_max)) ok = 0;
        if (ok && nch != 1 && nch != 2) ok = 0;
        if (ok)
        begin
            if (afmt == WavePcm && fmt_depth == 8) begin wid = 1; r.sample_format = 0; end
            else if (afmt == WavePcm && fmt_depth == 16) begin wid = 2; r.sample_format = 1; end
            else if (afmt == WavePcm && fmt_depth == 24) begin wid = 3; r.sample_format = 2; end
            else if (afmt == WaveFloat && fmt_depth == 32) begin wid = 4; r.sample_format = 3; end
            else ok = 0;
        end
        if (ok)
        begin
            r.channel_count = nch[1:0];
            r.sample_rate = rate;
            r.frame_count = data_len / (wid * nch);
            r.data_offset = data_pos;
        end
        else
            r = '0;
        r.status = !ok;
        return r;
    endfunction

    function automatic void predict_word(logic [7:0] b, logic fin);
        logic [31:0] tag, len;
        case (phase)
            PH_HEAD:
            begin
                if (hdr_count < 4)
                begin
                    if (b != TagRiff[8*hdr_count +: 8]) mark_bad();
                end
                else if (hdr_count < 8)
                begin
                    collect[8*(hdr_count-4) +: 8] = b;
                    if (hdr_count == 7) list_len = collect[31:0];
                end
                else if (hdr_count < 12)
                begin
                    if (b != TagWave[8*(hdr_count-8) +: 8]) mark_bad();
                    else if (hdr_count == 11)
                    begin
                        if (list_len < 4 || {1'b0, list_len} > LengthMax) mark_bad();
                        else
                        begin
                            list_len -= 4; list_pos = 0;
                            if (list_len == 0) phase = PH_DONE;
                            else open_header();
                        end
                    end
                end
            end
            PH_CHDR:
            begin
                collect[8*((8 - chunk_left) & 7) +: 8] = b;
                list_pos++; chunk_left--;
                if (chunk_left == 0)
                begin
                    tag = collect[31:0]; len = collect[63:32];
                    if ({1'b0, len} > LengthMax || len > list_len - list_pos) mark_bad();
                    else
                    begin
                        if (tag == TagFmt && !got_fmt)
                        begin
                            got_fmt = 1;
                            if (len < 16) mark_bad();
                            else fmt_in_chunk = 1;
                        end
                        if (!bad)
                        begin
                            if (tag == TagData && !got_data)
                            begin
                                got_data = 1; data_len = len; data_pos = 12 + list_pos;
                            end
                            if (len == 0) close_chunk();
                            else
                            begin
                                phase = PH_BODY; chunk_left = len;
                            end
                        end
                    end
                end
            end
            PH_BODY:
            begin
                if (fmt_in_chunk && fmt_got < 16)
                begin
                    if (fmt_got < 8) fmt_lo[8*fmt_got +: 8] = b;
                    else if (fmt_got >= 14) fmt_depth[8*(fmt_got-14) +: 8] = b;
                    fmt_got++;
                end
                list_pos++; chunk_left--;
                if (chunk_left == 0) close_chunk();
            end
            PH_PAD:
            begin
                list_pos++;
                if (list_pos == list_len) phase = PH_DONE;
                else open_header();
            end
            default: ;
        endcase
        if (hdr_count != 32'hFFFF_FFFF) hdr_count++;
        if (fin)
        begin
            expected_info.push_back(evaluate_file());
            clear_parse();
        end
    endfunction

    // one word per handshake; valid drops only when a gap is drawn
    task automatic send_word(logic [7:0] b, logic fin);
        int gap;
        gap = $urandom_range(0, 9) * $urandom_range(0, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1; data_byte <= b; last_byte <= fin;
        do @(posedge clk); while (!in_ready);
        predict_word(b, fin);
    endtask

    task automatic send_file(logic [7:0] f[$]);
        foreach (f[i]) send_word(f[i], i == f.size() - 1);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_info.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] v);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgMinRate) lim_min = v; else lim_max = v;
    endtask

    function automatic void put32(ref logic [7:0] f[$], input logic [31:0] v);
        for (int i = 0; i < 4; i++) f.push_back(v[8*i +: 8]);
    endfunction

    // builds a file; knobs bend it into the special cases
    function automatic void build_wave(ref logic [7:0] f[$], input logic [15:0] afmt,
                                       input logic [15:0] nch, input logic [31:0] rate,
                                       input logic [15:0] bits, input int dlen,
                                       input int fmt_len, input int extra_odd,
                                       input int riff_adj, input int trail);
        logic [7:0] lst[$];
        lst = {};
        if (extra_odd > 0)
        begin
            put32(lst, 32'h6B6E756A);
            put32(lst, 32'(extra_odd));
            repeat (extra_odd) lst.push_back(8'($urandom));
            if (extra_odd % 2) lst.push_back(8'($urandom));
        end
        put32(lst, TagFmt); put32(lst, 32'(fmt_len));
        for (int i = 0; i < fmt_len; i++)
        begin
            logic [7:0] v;
            v = 8'($urandom);
            if (i < 2) v = afmt[8*i +: 8];
            else if (i < 4) v = nch[8*(i-2) +: 8];
            else if (i < 8) v = rate[8*(i-4) +: 8];
            else if (i == 14 || i == 15) v = bits[8*(i-14) +: 8];
            lst.push_back(v);
        end
        if (fmt_len % 2) lst.push_back(8'd0);
        put32(lst, TagData); put32(lst, 32'(dlen));
        repeat (dlen) lst.push_back(8'($urandom));
        f = {};
        put32(f, TagRiff);
        put32(f, 32'(int'(lst.size()) + 4 + riff_adj));
        put32(f, TagWave);
        foreach (lst[i]) f.push_back(lst[i]);
        repeat (trail) f.push_back(8'($urandom));
    endfunction

    task automatic test_directed_formats();
        logic [7:0] f[$];
        build_wave(f, WavePcm, 1, 8000, 8, 7, 16, 0, 0, 0); send_file(f);
        build_wave(f, WavePcm, 2, 192000, 16, 9, 16, 3, 0, 2); send_file(f);
        build_wave(f, WavePcm, 2, 44100, 24, 13, 18, 0, 0, 0); send_file(f);
        build_wave(f, WaveFloat, 1, 48000, 32, 17, 16, 0, 0, 0); send_file(f);
        build_wave(f, WaveFloat, 3, 48000, 32, 8, 16, 0, 0, 0); send_file(f);
        build_wave(f, WavePcm, 1, 48000, 32, 8, 16, 0, 0, 0); send_file(f);
        build_wave(f, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4, 16, 0, 0, 0);
        send_file(f);
        build_wave(f, WavePcm, 1, 7999, 8, 4, 16, 0, 0, 0); send_file(f);
        build_wave(f, WavePcm, 1, 192001, 8, 4, 16, 0, 0, 0); send_file(f);
    endtask

    task automatic test_directed_structure();
        logic [7:0] f[$];
        // short fmt chunk
        build_wave(f, WavePcm, 1, 8000, 8, 4, 14, 0, 0, 0); send_file(f);
        // truncated file
        build_wave(f, WavePcm, 1, 8000, 8, 6, 16, 0, 0, 0);
        void'(f.pop_back()); send_file(f);
        // riff length too large for chunk bounds
        build_wave(f, WavePcm, 1, 8000, 8, 6, 16, 0, 5, 0); send_file(f);
        // odd data chunk ending exactly at list end
        build_wave(f, WavePcm, 1, 8000, 8, 5, 16, 0, 0, 0); send_file(f);
        // riff length 4 and below 4, bad tags, wide length, single byte
        f = {}; put32(f, TagRiff); put32(f, 4); put32(f, TagWave); send_file(f);
        f = {}; put32(f, TagRiff); put32(f, 3); put32(f, TagWave); send_file(f);
        f = {}; put32(f, TagRiff); put32(f, 32'hFFFF_FFFF); put32(f, TagWave);
        put32(f, TagData); put32(f, 32'hFFFF_FFF0); send_file(f);
        f = {}; put32(f, 32'h46464953); put32(f, 20); send_file(f);
        f = {}; put32(f, TagRiff); put32(f, 20); put32(f, 32'h45564158); send_file(f);
        f = {8'hFF}; send_file(f);
    endtask

    task automatic random_files(int words);
        logic [7:0] f[$];
        int sent = 0;
        int kind;
        while (sent < words)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                f = {};
                repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
            end
            else
            begin
                build_wave(f, $urandom_range(0, 3) == 0 ? WaveFloat : WavePcm,
                           16'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 2)),
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(6000, 200000),
                           16'(8 * $urandom_range(1, 4)), $urandom_range(0, 12),
                           $urandom_range(0, 7) == 0 ? $urandom_range(0, 18) : 16,
                           $urandom_range(0, 2) == 0 ? $urandom_range(1, 5) : 0,
                           kind == 1 ? int'($urandom_range(0, 6)) - 3 : 0,
                           $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
                if (kind == 2) f[$urandom_range(0, f.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
                if (kind == 3 && f.size() > 2) void'(f.pop_back());
            end
            send_file(f);
            sent += f.size();
        end
    endtask

    task automatic test_receiver_stall();
        logic [7:0] f[$];
        rx_hold = 1;
        build_wave(f, WavePcm, 2, 22050, 16, 8, 16, 0, 0, 0);
        fork
            begin
                send_file(f); send_file(f);
            end
            begin
                repeat (300) @(posedge clk);
                rx_hold = 0;
            end
        join
    endtask

    // result side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            wav_info_t e;
            if (expected_info.size() == 0)
            begin
                $error("result with no file pending");
                fail_count++;
            end
            else
            begin
                e = expected_info.pop_front();
                if (status !== e.status) begin $error("status exp %0h got %0h", e.status, status); fail_count++; end
                if (sample_format !== e.sample_format) begin $error("sample_format exp %0h got %0h", e.sample_format, sample_format); fail_count++; end
                if (channel_count !== e.channel_count) begin $error("channel_count exp %0h got %0h", e.channel_count, channel_count); fail_count++; end
                if (sample_rate !== e.sample_rate) begin $error("sample_rate exp %0h got %0h", e.sample_rate, sample_rate); fail_count++; end
                if (frame_count !== e.frame_count) begin $error("frame_count exp %0h got %0h", e.frame_count, frame_count); fail_count++; end
                if (data_offset !== e.data_offset) begin $error("data_offset exp %0h got %0h", e.data_offset, data_offset); fail_count++; end
            end
        end
    end

    int rx_wait = 0;
    always @(posedge clk)
    begin
        if (rx_hold)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            rx_wait = rx_stalls ? $urandom_range(0, 9) : 0;
            out_ready <= rx_wait == 0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= rx_wait == 0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        lim_min = 8000; lim_max = 192000;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_formats();
        test_directed_structure();
        test_receiver_stall();
        random_files(60);
        rx_stalls = 0;
        random_files(40);
        rx_stalls = 1;
        write_cfg(CfgMinRate, 32'd0);
        write_cfg(CfgMaxRate, 32'hFFFF_FFFF);
        random_files(40);
        write_cfg(CfgMinRate, 32'd50000);
        write_cfg(CfgMaxRate, 32'd40000);
        random_files(30);
        write_cfg(CfgMinRate, 32'd44100);
        write_cfg(CfgMaxRate, 32'd48000);
        random_files(40);
        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
